// File: design/assert_macros.svh
// Assertion macros shared by the repeated value finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds on every clock edge outside reset.
`define ASSERT_CHECK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CHECK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: design/rvf_pkg.sv
// Shared constants, types and helper functions of the repeated value finder.
`timescale 1ns / 1ps

package rvf_pkg;

  // Set geometry
  localparam int SET_SIZE   = 16;
  localparam int COUNT_W    = $clog2(SET_SIZE + 1);
  localparam int IDX_W      = $clog2(SET_SIZE);
  // Distinct repeated integers are at most half the set
  localparam int SEEN_DEPTH = SET_SIZE / 2;
  localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);
  localparam int SEEN_IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  typedef logic signed [31:0] value_t;
  typedef logic signed [15:0] int_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk_step;
    logic emit_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic few;
    logic walk_last;
    logic pipe_empty;
    logic out_free;
    logic emit_last;
  } status_t;

  // Integer part of a Q16.16 value, truncated toward zero
  function automatic int_t int_part(value_t v);
    logic [31:0] mag;
    mag = v[31] ? (~v + 32'd1) : v;
    return v[31] ? int_t'(~mag[31:16] + 16'd1) : int_t'(mag[31:16]);
  endfunction

endpackage

// File: design/rvf_in_if.sv
// Element input channel: valid/ready handshake with one set element.
`timescale 1ns / 1ps

interface rvf_in_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    sample_value;
  logic                  final_element;

  modport source (output valid, output sample_value, output final_element, input ready);
  modport sink   (input valid, input sample_value, input final_element, output ready);
endinterface

// File: design/rvf_out_if.sv
// Result output channel: valid/ready handshake with one repeated integer.
`timescale 1ns / 1ps

interface rvf_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    repeated_integer;
  logic                  none_repeated;
  logic                  run_end;

  modport source (output valid, output repeated_integer, output none_repeated,
                  output run_end, input ready);
  modport sink   (input valid, input repeated_integer, input none_repeated,
                  input run_end, output ready);
endinterface

// File: design/rvf_ctrl.sv
// Controller state machine of the repeated value finder.
`timescale 1ns / 1ps

module rvf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             final_element_i,
  output logic             in_ready_o,
  input  rvf_pkg::status_t status_i,
  output rvf_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Take elements only while loading a set
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && final_element_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.walk_start = 1'b1;
        state_d = status_i.few ? ST_DRAIN : ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_step = status_i.out_free;
        if (status_i.out_free && status_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/rvf_datapath.sv
// Datapath: element store, reverse pair walk, seen list and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rvf_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rvf_pkg::cmd_t          cmd_i,
  output rvf_pkg::status_t       status_o,
  input  logic signed [31:0]     sample_value_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [15:0]     repeated_integer_o,
  output logic                   none_repeated_o,
  output logic                   run_end_o
);

  // Element store, written while loading and read at two pair positions
  rvf_pkg::value_t mem_q [rvf_pkg::SET_SIZE];

  logic [rvf_pkg::COUNT_W-1:0]    count_q;
  logic [rvf_pkg::IDX_W-1:0]      i_q, j_q;
  logic                           store_wr;

  // Pair pipeline
  logic                           s1_vld_q;
  rvf_pkg::value_t                rd_a_q, rd_b_q;
  logic                           s2_hit_q;
  rvf_pkg::int_t                  s2_int_q;

  // Seen list of distinct integers, newest at the highest index
  rvf_pkg::int_t                  seen_q [rvf_pkg::SEEN_DEPTH];
  logic [rvf_pkg::SEEN_CNT_W-1:0] seen_cnt_q;
  logic [rvf_pkg::SEEN_IDX_W-1:0] e_q;
  logic                           match;
  logic                           push;
  logic                           none;
  logic                           emit_last;

  // Output register
  logic                           out_vld_q;
  rvf_pkg::int_t                  out_int_q;
  logic                           out_none_q;
  logic                           out_end_q;

  assign store_wr = cmd_i.load && (count_q < rvf_pkg::COUNT_W'(rvf_pkg::SET_SIZE));

  // Count stored elements, drop those beyond the store, clear after the set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.emit_step && emit_last) begin
      count_q <= '0;
    end else if (store_wr) begin
      count_q <= count_q + rvf_pkg::COUNT_W'(1);
    end
  end

  // Store write and pair reads
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      mem_q[count_q[rvf_pkg::IDX_W-1:0]] <= sample_value_i;
    end
    if (cmd_i.walk_step) begin
      rd_a_q <= mem_q[i_q];
      rd_b_q <= mem_q[j_q];
    end
  end

  // Walk pairs backward: i from the second last down, j from the last down to i+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.walk_start) begin
      i_q <= rvf_pkg::IDX_W'(count_q - rvf_pkg::COUNT_W'(2));
      j_q <= rvf_pkg::IDX_W'(count_q - rvf_pkg::COUNT_W'(1));
    end else if (cmd_i.walk_step) begin
      if (j_q == i_q + rvf_pkg::IDX_W'(1)) begin
        i_q <= i_q - rvf_pkg::IDX_W'(1);
        j_q <= rvf_pkg::IDX_W'(count_q - rvf_pkg::COUNT_W'(1));
      end else begin
        j_q <= j_q - rvf_pkg::IDX_W'(1);
      end
    end
  end

  // Compare the pair and take the integer part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_hit_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.walk_step;
      s2_hit_q <= s1_vld_q && (rd_a_q == rd_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_int_q <= rvf_pkg::int_part(rd_a_q);
  end

  // Look up the candidate among integers already seen later in the list
  always_comb begin
    match = 1'b0;
    for (int k = 0; k < rvf_pkg::SEEN_DEPTH; k++) begin
      if ((rvf_pkg::SEEN_CNT_W'(k) < seen_cnt_q) && (seen_q[k] == s2_int_q)) begin
        match = 1'b1;
      end
    end
  end

  assign push = s2_hit_q && !match;

  // Append new integers, track the newest entry for the emit walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_cnt_q <= '0;
      e_q        <= '0;
    end else if (cmd_i.walk_start) begin
      seen_cnt_q <= '0;
    end else if (push) begin
      seen_cnt_q <= seen_cnt_q + rvf_pkg::SEEN_CNT_W'(1);
      e_q        <= seen_cnt_q[rvf_pkg::SEEN_IDX_W-1:0];
    end else if (cmd_i.emit_step && !emit_last) begin
      e_q        <= e_q - rvf_pkg::SEEN_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      seen_q[seen_cnt_q[rvf_pkg::SEEN_IDX_W-1:0]] <= s2_int_q;
    end
  end

  assign none      = (seen_cnt_q == '0);
  assign emit_last = none || (e_q == '0);

  // Output register: load a result when empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_int_q  <= none ? '0 : seen_q[e_q];
      out_none_q <= none;
      out_end_q  <= emit_last;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign repeated_integer_o = out_int_q;
  assign none_repeated_o    = out_none_q;
  assign run_end_o          = out_end_q;

  // Status to the controller
  always_comb begin
    status_o            = '0;
    status_o.few        = (count_q < rvf_pkg::COUNT_W'(2));
    status_o.walk_last  = (i_q == '0) && (j_q == rvf_pkg::IDX_W'(1));
    status_o.pipe_empty = !s1_vld_q && !s2_hit_q;
    status_o.out_free   = !out_vld_q || out_ready_i;
    status_o.emit_last  = emit_last;
  end

  `ASSERT_NEVER(a_seen_overflow, clk_i, rst_ni, push && (seen_cnt_q == rvf_pkg::SEEN_CNT_W'(rvf_pkg::SEEN_DEPTH)), "seen list overflow")
  `ASSERT_CHECK(a_emit_after_drain, clk_i, rst_ni, cmd_i.emit_step |-> (!s1_vld_q && !s2_hit_q), "result emitted while pair pipeline busy")
  `ASSERT_CHECK(a_load_when_idle, clk_i, rst_ni, cmd_i.load |-> (!s1_vld_q && !s2_hit_q && !cmd_i.walk_step), "element loaded during pair walk")
  `ASSERT_CHECK(a_emit_index, clk_i, rst_ni, (cmd_i.emit_step && !none) |-> (rvf_pkg::SEEN_CNT_W'(e_q) < seen_cnt_q), "emit index beyond seen list")

endmodule

// File: design/repeated_value_finder.sv
// Top level of the repeated value finder: controller plus datapath.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+--------------------------------------------
//   in_i     | in  | valid / ready  | sample_value[31:0] s, final_element
//   out_o    | out | valid / ready  | repeated_integer[15:0] s, none_repeated,
//            |     |                | run_end
//
// Elements transfer one per cycle while a set loads. After the final element
// the block passes a setup state, then walks every pair of stored elements
// (n = stored elements, at most 16; no walk when n < 2) and drains the read
// and compare registers; then one result per cycle while the sink takes them.
// Input ready stays low from the final element until the last result enters
// the output register. Reset clears control state; the store needs none.
`timescale 1ns / 1ps

module repeated_value_finder (
  input  logic     clk_i,
  input  logic     rst_ni,
  rvf_in_if.sink   in_i,
  rvf_out_if.source out_o
);

  rvf_pkg::cmd_t    cmd;
  rvf_pkg::status_t status;

  rvf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .final_element_i (in_i.final_element),
    .in_ready_o      (in_i.ready),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  rvf_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .sample_value_i     (in_i.sample_value),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .repeated_integer_o (out_o.repeated_integer),
    .none_repeated_o    (out_o.none_repeated),
    .run_end_o          (out_o.run_end)
  );

endmodule
